// ===== rtl/fevd_pkg.sv =====
// Package: shared widths, constants and the queue entry type of the frame energy detector
package fevd_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;   // (-32768)^2 = 2^30 fits in 31 bits
    localparam int THR_W    = 31;
    localparam int SUM_W    = 43;

    // Defaults
    localparam int MAX_FRAME_SAMPLES_DEF = 4096;
    localparam logic [THR_W-1:0] THR_RESET = 31'd1073742;
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One classified item: its square, whether it counts, whether it ends a frame
    typedef struct packed {
        logic [SQ_W-1:0] sq;
        logic            inc;
        logic            last;
    } fevd_entry_t;

endpackage

// ===== rtl/fevd_front.sv =====
// Front: accepts samples, squares them and marks samples past the frame limit
module fevd_front
    import fevd_pkg::*;
#(
    parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       frame_end,
    output logic                       push_valid,
    input  logic                       push_ready,
    output fevd_entry_t                push_entry
);

    localparam int CNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_SAMPLES);

    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     s0_valid_reg, s0_valid_next;
    fevd_entry_t              s0_entry_reg, s0_entry_next;
    logic                     accept;
    logic                     inc;
    logic signed [2*SAMPLE_W-1:0] prod;

    // Hold the input while the staged item cannot enter the queue
    assign in_stall   = s0_valid_reg && !push_ready;
    assign accept     = in_valid && !in_stall;
    assign push_valid = s0_valid_reg;
    assign push_entry = s0_entry_reg;

    // Square and classify
    assign inc  = (cnt_reg < CNT_MAX);
    assign prod = sample * sample;

    always_comb
    begin
        cnt_next      = cnt_reg;
        s0_valid_next = s0_valid_reg;
        s0_entry_next = s0_entry_reg;
        if (s0_valid_reg && push_ready)
        begin
            s0_valid_next = 1'b0;
        end
        if (accept)
        begin
            s0_valid_next      = 1'b1;
            s0_entry_next.sq   = inc ? prod[SQ_W-1:0] : '0;
            s0_entry_next.inc  = inc;
            s0_entry_next.last = frame_end;
            if (frame_end)
            begin
                cnt_next = '0;
            end
            else if (inc)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            s0_valid_reg <= s0_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        s0_entry_reg <= s0_entry_next;
    end

endmodule

// ===== rtl/fevd_queue.sv =====
// Queue: small FIFO of classified items between front and back
module fevd_queue
    import fevd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    output logic        push_ready,
    input  fevd_entry_t push_entry,
    output logic        pop_valid,
    input  logic        pop_ready,
    output fevd_entry_t pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    fevd_entry_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, wptr_next;
    logic [PTR_W-1:0]  rptr_reg, rptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_entry  = mem_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wptr_next = do_push ? PTR_W'(wptr_reg + PTR_W'(1)) : wptr_reg;
        rptr_next = do_pop ? PTR_W'(rptr_reg + PTR_W'(1)) : rptr_reg;
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/fevd_back.sv =====
// Back: accumulates squares, forms the frame decision and holds the result register
module fevd_back
    import fevd_pkg::*;
#(
    parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  fevd_entry_t      pop_entry,
    input  logic [THR_W-1:0] thr,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             voice_detected
);

    localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int PROD_W = CNT_W + THR_W;
    localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

    // Accumulator
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;
    logic [CNT_W-1:0]  cnt_inc;
    logic              do_pop;

    // Decision pipeline: s1 totals, s2 product, then output
    logic              s1_valid_reg, s1_valid_next;
    logic [SUM_W-1:0]  s1_sum_reg;
    logic [CNT_W-1:0]  s1_cnt_reg;
    logic              s2_valid_reg, s2_valid_next;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic              s2_rms_reg;
    logic              out_valid_reg, out_valid_next;
    logic              voice_reg;
    logic              out_ready, s2_ready, s1_ready;
    logic              s1_load, s2_load, out_load;

    // Ready chain from the output back
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop_ready = !pop_entry.last || s1_ready;
    assign do_pop    = pop_valid && pop_ready;
    assign s1_load   = do_pop && pop_entry.last;
    assign s2_load   = s1_valid_reg && s2_ready;
    assign out_load  = s2_valid_reg && out_ready;

    // Saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(pop_entry.sq);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign cnt_inc  = cnt_reg + CNT_W'(pop_entry.inc);

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (do_pop)
        begin
            if (pop_entry.last)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_sat;
                cnt_next = cnt_inc;
            end
        end
    end

    // Stage valids
    always_comb
    begin
        s1_valid_next  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s2_load ? 1'b1 : (out_load ? 1'b0 : s2_valid_reg);
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_sum_reg <= sum_sat;
            s1_cnt_reg <= cnt_inc;
        end
        if (s2_load)
        begin
            s2_sum_reg  <= s1_sum_reg;
            s2_prod_reg <= PROD_W'(s1_cnt_reg) * PROD_W'(thr);
            s2_rms_reg  <= (s1_sum_reg >= SUM_W'(s1_cnt_reg));
        end
        if (out_load)
        begin
            voice_reg <= s2_rms_reg && (CMP_W'(s2_sum_reg) >= CMP_W'(s2_prod_reg));
        end
    end

    assign out_valid      = out_valid_reg;
    assign voice_detected = voice_reg;

endmodule

// ===== rtl/frame_energy_voice_detector.sv =====
// Top level: frame energy voice activity detector
//
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------
//  in      | in_valid / in_stall       | sample[15:0] s, frame_end
//  out     | out_valid / out_stall     | voice_detected
//  cfg     | cfg_valid / cfg_ready     | energy_threshold[30:0]
//
//  Unless stalled, one sample is accepted each cycle; square and accumulate keep up.
//  A frame's decision passes the staging register, queue, s1, s2 and output.
//  Queue of four items decouples the square stage from accumulate and decision.
//  out_stall backs up the decision pipeline; in_stall rises once the queue fills.
//  rst_n clears counters, accumulator and valids; threshold resets to about -30 dB.
module frame_energy_voice_detector
    import fevd_pkg::*;
#(
    parameter int MAX_FRAME_SAMPLES = MAX_FRAME_SAMPLES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       frame_end,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       voice_detected,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [THR_W-1:0]           energy_threshold
);

    logic [THR_W-1:0] thr_reg;
    logic             push_valid, push_ready;
    fevd_entry_t      push_entry;
    logic             pop_valid, pop_ready;
    fevd_entry_t      pop_entry;

    // Threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= energy_threshold;
        end
    end

    fevd_front #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .frame_end  (frame_end),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    fevd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    fevd_back #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_entry      (pop_entry),
        .thr            (thr_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .voice_detected (voice_detected)
    );

endmodule

// ===== rtl/fevd_checker.sv =====
// Checker: port-level assertions for the frame energy detector, bound to the top level
module fevd_checker
    import fevd_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic signed [SAMPLE_W-1:0] sample,
    input logic                       frame_end,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       voice_detected,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic [THR_W-1:0]           energy_threshold
);

    // Frames accepted whose decision is not yet taken
    logic [3:0] pend_reg, pend_next;
    logic       fe_acc, out_acc;

    assign fe_acc  = in_valid && !in_stall && frame_end;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg + 4'(fe_acc) - 4'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled decision holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(voice_detected))
        else $error("decision changed while stalled");

    // No decision without an ended frame
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("decision without a pending frame");

    // Frames in flight stay within the pipeline and queue capacity
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 4'd8)
        else $error("too many frames in flight");

    // Threshold port is always open
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("threshold write refused");

endmodule

bind frame_energy_voice_detector fevd_checker u_fevd_checker (.*);
